// ===== design/scancode_keyboard_line_discipline_core_defines.svh =====
// Assertion macros for the checker file
`ifndef SCANCODE_KEYBOARD_LINE_DISCIPLINE_CORE_DEFINES_SVH
`define SCANCODE_KEYBOARD_LINE_DISCIPLINE_CORE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define SKLD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define SKLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/skld_pkg.sv =====
`timescale 1ns / 1ps
package skld_pkg;

    localparam logic [1:0] OP_SCAN  = 2'd0;
    localparam logic [1:0] OP_MODE  = 2'd1;
    localparam logic [1:0] OP_POP   = 2'd2;
    localparam logic [1:0] OP_LOAD  = 2'd3;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_ECHO   = 3'd1;
    localparam logic [2:0] KIND_POP    = 3'd2;
    localparam logic [2:0] KIND_BKSP   = 3'd3;
    localparam logic [2:0] KIND_SCR_UP = 3'd4;
    localparam logic [2:0] KIND_SCR_DN = 3'd5;
    localparam logic [2:0] KIND_LED    = 3'd6;
    localparam logic [2:0] KIND_EMPTY  = 3'd7;

    localparam logic [2:0] REG_LSHIFT = 3'd0;
    localparam logic [2:0] REG_RSHIFT = 3'd1;
    localparam logic [2:0] REG_CAPS   = 3'd2;
    localparam logic [2:0] REG_BKSP   = 3'd3;
    localparam logic [2:0] REG_PGUP   = 3'd4;
    localparam logic [2:0] REG_PGDN   = 3'd5;

    localparam logic [7:0] EXT_PREFIX = 8'hE0;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;

    // Input item as carried through the command queue
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] scan_byte;
        logic [2:0] new_mode;
        logic [1:0] table_select;
        logic [6:0] table_index;
        logic [7:0] table_char;
    } item_t;

endpackage

// ===== design/scancode_keyboard_line_discipline_core.sv =====
`timescale 1ns / 1ps
// Channel    | Dir | Content
// s_axis     | in  | tdata: opcode, scan_byte, new_mode, table_select, table_index, table_char
// m_axis     | out | tdata: kind, char_value, caps_led, key_count, dropped; tlast: last
// cfg        | in  | cfg_we, cfg_index, cfg_data (registers 0..5)
// Once taken from the input queue an item goes from idle straight to emit (extended byte,
// mode change, table load), through look (release) or pop read (pop), or through look and
// decide (make code); emit holds for a second beat when there is one. A line drain runs
// drain read then drain write per line byte, one line read per byte, and one more pair to end it.
// Reset clears all control state; table and queue memories are not cleared.
// The two-entry input queue keeps accepting, until it is full, while a result waits on m_axis_tready.
module scancode_keyboard_line_discipline_core
    import skld_pkg::*;
#(
    parameter int KEY_QUEUE_DEPTH = 64,
    parameter int LINE_DEPTH      = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], scan_byte[9:2], new_mode[12:10], table_select[14:13],
    // table_index[21:15], table_char[29:22]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // kind[2:0], char_value[10:3], caps_led[11], key_count[18:12], dropped[19]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    item_t      in_item, q_item;
    logic       q_valid, q_take;
    logic [2:0] r_kind;
    logic [7:0] r_char;
    logic       r_caps, r_drop;
    logic [6:0] r_count;

    assign in_item.opcode       = s_axis_tdata[1:0];
    assign in_item.scan_byte    = s_axis_tdata[9:2];
    assign in_item.new_mode     = s_axis_tdata[12:10];
    assign in_item.table_select = s_axis_tdata[14:13];
    assign in_item.table_index  = s_axis_tdata[21:15];
    assign in_item.table_char   = s_axis_tdata[29:22];

    skld_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_item   (q_item)
    );

    skld_back #(
        .KEY_QUEUE_DEPTH (KEY_QUEUE_DEPTH),
        .LINE_DEPTH      (LINE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_valid     (q_valid),
        .q_take      (q_take),
        .q_item      (q_item),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_kind    (r_kind),
        .res_char    (r_char),
        .res_caps    (r_caps),
        .res_count   (r_count),
        .res_dropped (r_drop),
        .res_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, r_drop, r_count, r_caps, r_char, r_kind};
endmodule

// ===== design/skld_front.sv =====
`timescale 1ns / 1ps
// Input skid queue: two-entry FIFO that takes beats from the stream side
module skld_front
    import skld_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  q_valid,
    input  logic  q_take,
    output item_t q_item
);
    item_t       mem_reg [2];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_take;
    assign q_item   = mem_reg[rptr_reg];

    // Store accepted beats
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

    // Advance pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== design/skld_back.sv =====
`timescale 1ns / 1ps
// Execution engine: decodes one queued item, walks tables and queues,
// and hands up to two results to the output register.
module skld_back
    import skld_pkg::*;
#(
    parameter int KEY_QUEUE_DEPTH = 64,
    parameter int LINE_DEPTH      = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        q_valid,
    output logic        q_take,
    input  item_t       q_item,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [2:0]  res_kind,
    output logic [7:0]  res_char,
    output logic        res_caps,
    output logic [6:0]  res_count,
    output logic        res_dropped,
    output logic        res_last
);
    localparam int KQW = $clog2(KEY_QUEUE_DEPTH);
    localparam int KCW = $clog2(KEY_QUEUE_DEPTH + 1);
    localparam int LW  = $clog2(LINE_DEPTH);
    localparam int LCW = $clog2(LINE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOK, ST_DECIDE, ST_DRAIN_RD, ST_DRAIN_WR, ST_POP_RD, ST_EMIT
    } state_t;

    state_t           state_reg;
    logic [6:0]       cfg_reg [6];
    logic [1:0]       shift_reg;
    logic             caps_reg, ext_reg;
    logic [2:0]       mode_reg;
    logic [KQW-1:0]   head_reg, tail_reg;
    logic [KCW-1:0]   kcnt_reg;
    logic [LCW-1:0]   lcnt_reg;
    logic [LCW-1:0]   didx_reg;
    logic             drop_reg, nl_after_reg;
    item_t            it_reg;
    logic [2:0]       k0_reg, k1_reg;
    logic [7:0]       c0_reg, c1_reg;
    logic             two_reg, second_reg;

    logic [7:0]       kq_mem [KEY_QUEUE_DEPTH];
    logic [7:0]       ln_mem [LINE_DEPTH];
    logic [7:0]       tb_mem [512];
    logic [7:0]       tb_rd_reg, ln_rd_reg, kq_rd_reg;

    // Memory write requests from the sequencer
    logic             kq_we, ln_we, tb_we;
    logic [7:0]       kq_wd, ln_wd;
    logic [LW-1:0]    ln_wa;
    logic [8:0]       tb_a;
    logic [LW-1:0]    ln_ra;

    logic [6:0]       code;
    logic             rel;
    logic [1:0]       sel;

    assign code = it_reg.scan_byte[6:0];
    assign rel  = it_reg.scan_byte[7];
    assign ln_ra = didx_reg[LW-1:0];

    assign tb_we = (state_reg == ST_IDLE) && q_valid && (q_item.opcode == OP_LOAD);

    // Table, line and key memories with registered reads
    always_ff @(posedge clk)
    begin
        if (tb_we)
        begin
            tb_mem[tb_a] <= q_item.table_char;
        end
        tb_rd_reg <= tb_mem[tb_a];
        if (ln_we)
        begin
            ln_mem[ln_wa] <= ln_wd;
        end
        ln_rd_reg <= ln_mem[ln_ra];
        if (kq_we)
        begin
            kq_mem[tail_reg] <= kq_wd;
        end
        kq_rd_reg <= kq_mem[head_reg];
    end

    logic kq_full;
    assign kq_full = (kcnt_reg == KCW'(KEY_QUEUE_DEPTH));

    // Decide-stage values from the looked-up character
    logic [7:0] ch;
    logic       printable, is_l, is_r, is_c, is_b;
    assign ch        = tb_rd_reg;
    assign printable = (ch >= CH_TAB) && !ch[7];
    assign is_l = (code == cfg_reg[REG_LSHIFT]);
    assign is_r = !is_l && (code == cfg_reg[REG_RSHIFT]);
    assign is_c = !is_l && !is_r && (code == cfg_reg[REG_CAPS]);
    assign is_b = !is_l && !is_r && !is_c && (code == cfg_reg[REG_BKSP]);

    // Select the table from the modifier state this byte leaves behind
    logic [1:0] shift_upd;
    logic       caps_upd;
    assign shift_upd = {is_r ? !rel : shift_reg[1], is_l ? !rel : shift_reg[0]};
    assign caps_upd  = caps_reg ^ (is_c && !rel);
    assign sel       = {caps_upd, shift_upd != 2'b00};
    assign tb_a = (state_reg == ST_IDLE) ? {q_item.table_select, q_item.table_index}
                                         : {sel, code};

    // Combinational write strobes
    always_comb
    begin
        kq_we = 1'b0;
        kq_wd = 8'd0;
        ln_we = 1'b0;
        ln_wd = ch;
        ln_wa = lcnt_reg[LW-1:0];
        unique case (state_reg)
            ST_LOOK:
            begin
                kq_we = mode_reg[0] && !kq_full;
                kq_wd = it_reg.scan_byte;
            end
            ST_DECIDE:
            begin
                if (!rel)
                begin
                    if (ch != 8'd0 && mode_reg[1:0] == 2'b00)
                    begin
                        kq_we = !kq_full;
                        kq_wd = ch;
                    end
                    else if (printable && mode_reg[1] && ch != CH_NL)
                    begin
                        ln_we = (lcnt_reg != LCW'(LINE_DEPTH));
                    end
                end
            end
            ST_DRAIN_WR:
            begin
                if (didx_reg < lcnt_reg)
                begin
                    kq_we = !kq_full;
                    kq_wd = ln_rd_reg;
                end
                else if (nl_after_reg)
                begin
                    kq_we = !kq_full;
                    kq_wd = CH_NL;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer state and registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cfg_reg[0]  <= 7'd42;
            cfg_reg[1]  <= 7'd54;
            cfg_reg[2]  <= 7'd58;
            cfg_reg[3]  <= 7'd14;
            cfg_reg[4]  <= 7'd73;
            cfg_reg[5]  <= 7'd81;
            shift_reg   <= 2'b00;
            caps_reg    <= 1'b0;
            ext_reg     <= 1'b0;
            mode_reg    <= 3'd0;
            head_reg    <= '0;
            tail_reg    <= '0;
            kcnt_reg    <= '0;
            lcnt_reg    <= '0;
            didx_reg    <= '0;
            drop_reg    <= 1'b0;
            nl_after_reg <= 1'b0;
            k0_reg      <= KIND_NONE;
            k1_reg      <= KIND_NONE;
            c0_reg      <= 8'd0;
            c1_reg      <= 8'd0;
            two_reg     <= 1'b0;
            second_reg  <= 1'b0;
            it_reg      <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index < 3'd6)
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
            // Key queue tail on every push, drop on a full queue
            if (kq_we)
            begin
                tail_reg <= (tail_reg == KQW'(KEY_QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        it_reg     <= q_item;
                        drop_reg   <= 1'b0;
                        k0_reg     <= KIND_NONE;
                        c0_reg     <= 8'd0;
                        two_reg    <= 1'b0;
                        second_reg <= 1'b0;
                        unique case (q_item.opcode)
                            OP_SCAN:
                            begin
                                if (q_item.scan_byte == EXT_PREFIX)
                                begin
                                    ext_reg   <= 1'b1;
                                    state_reg <= ST_EMIT;
                                end
                                else if (ext_reg)
                                begin
                                    ext_reg <= 1'b0;
                                    if (q_item.scan_byte[7] && shift_reg != 2'b00)
                                    begin
                                        if (q_item.scan_byte[6:0] == cfg_reg[REG_PGUP])
                                        begin
                                            k0_reg <= KIND_SCR_UP;
                                        end
                                        else if (q_item.scan_byte[6:0] == cfg_reg[REG_PGDN])
                                        begin
                                            k0_reg <= KIND_SCR_DN;
                                        end
                                    end
                                    state_reg <= ST_EMIT;
                                end
                                else
                                begin
                                    state_reg <= ST_LOOK;
                                end
                            end
                            OP_MODE:
                            begin
                                mode_reg <= q_item.new_mode;
                                if (q_item.new_mode[0] != mode_reg[0])
                                begin
                                    head_reg <= '0;
                                    tail_reg <= '0;
                                    kcnt_reg <= '0;
                                end
                                if (mode_reg[1] && !q_item.new_mode[1])
                                begin
                                    didx_reg     <= '0;
                                    nl_after_reg <= 1'b0;
                                    state_reg    <= ST_DRAIN_RD;
                                end
                                else
                                begin
                                    state_reg <= ST_EMIT;
                                end
                            end
                            OP_POP:
                            begin
                                state_reg <= ST_POP_RD;
                            end
                            default:
                            begin
                                state_reg <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_LOOK:
                begin
                    // Table read in flight; raw push and modifier tracking
                    if (mode_reg[0])
                    begin
                        if (kq_full)
                        begin
                            drop_reg <= 1'b1;
                        end
                        else
                        begin
                            kcnt_reg <= kcnt_reg + 1'b1;
                        end
                    end
                    if (is_l)
                    begin
                        shift_reg[0] <= !rel;
                    end
                    if (is_r)
                    begin
                        shift_reg[1] <= !rel;
                    end
                    if (is_c && !rel)
                    begin
                        caps_reg <= ~caps_reg;
                        k0_reg   <= KIND_LED;
                    end
                    if (is_b && mode_reg[1] && !rel && lcnt_reg != '0)
                    begin
                        lcnt_reg <= lcnt_reg - 1'b1;
                        k0_reg   <= KIND_BKSP;
                    end
                    state_reg <= rel ? ST_EMIT : ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    state_reg <= ST_EMIT;
                    if (printable && mode_reg[2])
                    begin
                        if (k0_reg == KIND_NONE)
                        begin
                            k0_reg <= KIND_ECHO;
                            c0_reg <= ch;
                        end
                        else
                        begin
                            k1_reg  <= KIND_ECHO;
                            c1_reg  <= ch;
                            two_reg <= 1'b1;
                        end
                    end
                    if (ch != 8'd0 && mode_reg[1:0] == 2'b00)
                    begin
                        if (kq_full)
                        begin
                            drop_reg <= 1'b1;
                        end
                        else
                        begin
                            kcnt_reg <= kcnt_reg + 1'b1;
                        end
                    end
                    else if (printable && mode_reg[1])
                    begin
                        if (ch == CH_NL)
                        begin
                            didx_reg     <= '0;
                            nl_after_reg <= 1'b1;
                            state_reg    <= ST_DRAIN_RD;
                        end
                        else if (lcnt_reg == LCW'(LINE_DEPTH))
                        begin
                            drop_reg <= 1'b1;
                        end
                        else
                        begin
                            lcnt_reg <= lcnt_reg + 1'b1;
                        end
                    end
                end
                ST_DRAIN_RD:
                begin
                    state_reg <= ST_DRAIN_WR;
                end
                ST_DRAIN_WR:
                begin
                    if (didx_reg < lcnt_reg || nl_after_reg)
                    begin
                        if (kq_full)
                        begin
                            drop_reg <= 1'b1;
                        end
                        else
                        begin
                            kcnt_reg <= kcnt_reg + 1'b1;
                        end
                    end
                    if (didx_reg < lcnt_reg)
                    begin
                        didx_reg  <= didx_reg + 1'b1;
                        state_reg <= ST_DRAIN_RD;
                    end
                    else
                    begin
                        lcnt_reg     <= '0;
                        nl_after_reg <= 1'b0;
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_POP_RD:
                begin
                    if (kcnt_reg == '0)
                    begin
                        k0_reg <= KIND_EMPTY;
                    end
                    else
                    begin
                        k0_reg   <= KIND_POP;
                        c0_reg   <= kq_rd_reg;
                        head_reg <= (head_reg == KQW'(KEY_QUEUE_DEPTH - 1)) ?
                                    '0 : head_reg + 1'b1;
                        kcnt_reg <= kcnt_reg - 1'b1;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (res_ready)
                    begin
                        if (two_reg && !second_reg)
                        begin
                            second_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign q_take      = (state_reg == ST_IDLE) && q_valid;
    assign res_valid   = (state_reg == ST_EMIT);
    assign res_kind    = second_reg ? k1_reg : k0_reg;
    assign res_char    = second_reg ? c1_reg : c0_reg;
    assign res_caps    = caps_reg;
    assign res_count   = 7'(kcnt_reg);
    assign res_dropped = drop_reg;
    assign res_last    = !two_reg || second_reg;
endmodule

// ===== design/skld_checker.sv =====
`timescale 1ns / 1ps
`include "scancode_keyboard_line_discipline_core_defines.svh"
// Port-level checks on the result stream
module skld_checker
    import skld_pkg::*;
#(
    parameter int KEY_QUEUE_DEPTH = 64
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // A stalled beat holds
    `SKLD_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")
    // Key count never exceeds the queue depth
    `SKLD_ASSERT_IMP(a_count, clk, rst_n, m_axis_tvalid, int'(m_axis_tdata[18:12]) <= KEY_QUEUE_DEPTH, "key count out of range")
    // A non-final beat is a LED or backspace report
    `SKLD_ASSERT_IMP(a_first, clk, rst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[2:0] == KIND_LED || m_axis_tdata[2:0] == KIND_BKSP, "bad first result")
    // Padding stays zero
    `SKLD_ASSERT_IMP(a_pad, clk, rst_n, m_axis_tvalid, m_axis_tdata[23:20] == 4'd0, "padding set")
endmodule

bind scancode_keyboard_line_discipline_core skld_checker #(
    .KEY_QUEUE_DEPTH (KEY_QUEUE_DEPTH)
) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== dv/scancode_keyboard_line_discipline_core_tb.sv =====
`timescale 1ns / 1ps
module scancode_keyboard_line_discipline_core_tb;
    import skld_pkg::*;

    localparam int QDEPTH = 64;
    localparam int LDEPTH = 64;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int NCODES = 30;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // opcode[1:0], scan_byte[9:2], new_mode[12:10], table_select[14:13],
    // table_index[21:15], table_char[29:22]
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // kind[2:0], char_value[10:3], caps_led[11], key_count[18:12], dropped[19]
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [6:0]  cfg_data;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic       led;
        logic [6:0] count;
        logic       dropped;
        logic       last;
    } keyev_t;

    // Predictor state
    logic [6:0] key_regs [6];
    logic [1:0] shift_held;
    logic       caps_on;
    logic       ext_wait;
    logic [2:0] mode_bits;
    logic [7:0] keyq [QDEPTH];
    int         keyq_head, keyq_fill;
    logic [7:0] line_hold [LDEPTH];
    int         line_fill;
    logic [7:0] xlat [512];
    bit         xlat_known [512];
    bit         lost;

    keyev_t pending_events [$];
    int     err_count;
    int     beat_count;
    int     cycle_count;
    bit     sink_stall_on;
    int     sink_wait;
    int     kind_seen [8];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    scancode_keyboard_line_discipline_core uut (.*);

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("scancode_keyboard_line_discipline_core test failed");
            $finish;
        end
    end

    // Sink side: random stalls, compare each beat
    always @(posedge clk)
    begin
        keyev_t got, exp_ev;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.kind    = m_axis_tdata[2:0];
            got.ch      = m_axis_tdata[10:3];
            got.led     = m_axis_tdata[11];
            got.count   = m_axis_tdata[18:12];
            got.dropped = m_axis_tdata[19];
            got.last    = m_axis_tlast;
            beat_count <= beat_count + 1;
            if (pending_events.size() == 0)
            begin
                err_count = err_count + 1;
                if (err_count <= 10)
                    $display("unexpected beat %h", got);
            end
            else
            begin
                exp_ev = pending_events.pop_front();
                kind_seen[exp_ev.kind] = kind_seen[exp_ev.kind] + 1;
                if (got !== exp_ev)
                begin
                    err_count = err_count + 1;
                    if (err_count <= 10)
                        $display("mismatch: kind %0d/%0d ch %h/%h led %b/%b cnt %0d/%0d drop %b/%b last %b/%b",
                            exp_ev.kind, got.kind, exp_ev.ch, got.ch, exp_ev.led, got.led,
                            exp_ev.count, got.count, exp_ev.dropped, got.dropped,
                            exp_ev.last, got.last);
                end
            end
            sink_wait = sink_stall_on ? int'($urandom_range(0, 4)) : 0;
        end
        else if (m_axis_tvalid && sink_wait > 0)
            sink_wait = sink_wait - 1;
        m_axis_tready <= (sink_wait == 0);
    end

    // Make codes the stimulus may translate; every table holds them
    function automatic logic [6:0] code_at(input int r);
        logic [6:0] v;
        if (r < 24)
            v = 7'(r);
        else if (r == 24)
            v = 7'd42;
        else if (r == 25)
            v = 7'd54;
        else if (r == 26)
            v = 7'd58;
        else if (r == 27)
            v = 7'd73;
        else if (r == 28)
            v = 7'd81;
        else
            v = 7'd127;
        return v;
    endfunction

    function automatic logic [6:0] pick_code();
        return code_at(int'($urandom_range(0, NCODES - 1)));
    endfunction

    function automatic void push_key(input logic [7:0] v);
        if (keyq_fill >= QDEPTH)
            lost = 1'b1;
        else
        begin
            keyq[(keyq_head + keyq_fill) % QDEPTH] = v;
            keyq_fill = keyq_fill + 1;
        end
    endfunction

    function automatic void flush_line();
        for (int i = 0; i < line_fill; i++)
            push_key(line_hold[i]);
        line_fill = 0;
    endfunction

    function automatic void record_event(input logic [2:0] k, input logic [7:0] c);
        keyev_t e;
        e.kind = k;
        e.ch = c;
        e.led = caps_on;
        e.count = keyq_fill[6:0];
        e.dropped = lost;
        e.last = 1'b0;
        pending_events.push_back(e);
    endfunction

    // Work out the beats one command produces
    function automatic void predict_keyboard(input item_t it);
        logic [2:0] kinds [2];
        logic [7:0] chars [2];
        int         n;
        logic [6:0] code;
        bit         rel;
        logic [7:0] c;
        bit         printable;
        keyev_t     tail;
        n = 0;
        lost = 1'b0;
        code = it.scan_byte[6:0];
        rel = it.scan_byte[7];
        case (it.opcode)
            OP_SCAN:
            begin
                if (it.scan_byte == EXT_PREFIX)
                    ext_wait = 1'b1;
                else if (ext_wait)
                begin
                    ext_wait = 1'b0;
                    if (rel && shift_held != 2'b00)
                    begin
                        if (code == key_regs[REG_PGUP])
                        begin
                            kinds[n] = KIND_SCR_UP; chars[n] = 8'h00; n++;
                        end
                        else if (code == key_regs[REG_PGDN])
                        begin
                            kinds[n] = KIND_SCR_DN; chars[n] = 8'h00; n++;
                        end
                    end
                end
                else
                begin
                    if (mode_bits[0])
                        push_key(it.scan_byte);
                    if (code == key_regs[REG_LSHIFT])
                        shift_held[0] = !rel;
                    else if (code == key_regs[REG_RSHIFT])
                        shift_held[1] = !rel;
                    else if (code == key_regs[REG_CAPS])
                    begin
                        if (!rel)
                        begin
                            caps_on = !caps_on;
                            kinds[n] = KIND_LED; chars[n] = 8'h00; n++;
                        end
                    end
                    else if (code == key_regs[REG_BKSP])
                    begin
                        if (mode_bits[1] && !rel && line_fill > 0)
                        begin
                            line_fill = line_fill - 1;
                            kinds[n] = KIND_BKSP; chars[n] = 8'h00; n++;
                        end
                    end
                    if (!rel)
                    begin
                        c = xlat[{caps_on, shift_held != 2'b00, code}];
                        printable = (c >= CH_TAB) && (c <= 8'd127);
                        if (printable && mode_bits[2])
                        begin
                            kinds[n] = KIND_ECHO; chars[n] = c; n++;
                        end
                        if (c != 8'h00 && mode_bits[1:0] == 2'b00)
                            push_key(c);
                        else if (printable && mode_bits[1])
                        begin
                            if (c == CH_NL)
                            begin
                                flush_line();
                                push_key(CH_NL);
                            end
                            else if (line_fill >= LDEPTH)
                                lost = 1'b1;
                            else
                            begin
                                line_hold[line_fill] = c;
                                line_fill = line_fill + 1;
                            end
                        end
                    end
                end
            end
            OP_MODE:
            begin
                if (it.new_mode[0] != mode_bits[0])
                begin
                    keyq_head = 0;
                    keyq_fill = 0;
                end
                if (mode_bits[1] && !it.new_mode[1])
                    flush_line();
                mode_bits = it.new_mode;
            end
            OP_POP:
            begin
                if (keyq_fill == 0)
                begin
                    kinds[n] = KIND_EMPTY; chars[n] = 8'h00; n++;
                end
                else
                begin
                    kinds[n] = KIND_POP; chars[n] = keyq[keyq_head]; n++;
                    keyq_head = (keyq_head + 1) % QDEPTH;
                    keyq_fill = keyq_fill - 1;
                end
            end
            default:
            begin
                xlat[{it.table_select, it.table_index}] = it.table_char;
                xlat_known[{it.table_select, it.table_index}] = 1'b1;
            end
        endcase
        if (n == 0)
        begin
            kinds[0] = KIND_NONE; chars[0] = 8'h00; n = 1;
        end
        for (int k = 0; k < n; k++)
            record_event(kinds[k], chars[k]);
        tail = pending_events.pop_back();
        tail.last = 1'b1;
        pending_events.push_back(tail);
    endfunction

    // Send one command beat after a random gap
    task automatic send_item(input item_t it);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= {2'b00, it.table_char, it.table_index, it.table_select,
                         it.new_mode, it.scan_byte, it.opcode};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_keyboard(it);
    endtask

    task automatic send_op(input logic [1:0] op, input logic [7:0] sb, input logic [2:0] nm,
                           input logic [1:0] ts, input logic [6:0] ti, input logic [7:0] tc);
        item_t it;
        it.opcode = op;
        it.scan_byte = sb;
        it.new_mode = nm;
        it.table_select = ts;
        it.table_index = ti;
        it.table_char = tc;
        send_item(it);
    endtask

    task automatic scan_key(input logic [7:0] sb);
        send_op(OP_SCAN, sb, 3'd0, 2'd0, 7'd0, 8'd0);
    endtask

    // Stop sending and hold until every expected beat has come
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (2 * LDEPTH + 20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        key_regs[idx] = val;
        @(posedge clk);
    endtask

    // Fill all four tables for every code that is ever translated
    task automatic test_table_load();
        for (int s = 0; s < 4; s++)
            for (int i = 0; i < NCODES; i++)
                send_op(OP_LOAD, 8'($urandom), 3'($urandom), 2'(s), code_at(i),
                        ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                        : 8'($urandom_range(32, 126)));
        // Edges and newline / tab / zero entries
        send_op(OP_LOAD, 8'hFF, 3'd7, 2'd0, 7'd16, 8'h0A);
        send_op(OP_LOAD, 8'h00, 3'd0, 2'd1, 7'd16, 8'h0A);
        send_op(OP_LOAD, 8'h00, 3'd0, 2'd0, 7'd17, 8'h09);
        send_op(OP_LOAD, 8'h00, 3'd0, 2'd0, 7'd18, 8'h00);
        send_op(OP_LOAD, 8'h00, 3'd0, 2'd0, 7'd19, 8'hFF);
        send_op(OP_LOAD, 8'h00, 3'd0, 2'd3, 7'd127, 8'h80);
        send_op(OP_LOAD, 8'h00, 3'd0, 2'd2, 7'd0, 8'h08);
    endtask

    task automatic test_directed();
        send_op(OP_POP, 8'h00, 3'd0, 2'd0, 7'd0, 8'd0);
        scan_key(8'd17);
        scan_key(8'd19);
        scan_key(8'd18);
        scan_key(8'd58);
        scan_key(8'd58 | 8'h80);
        send_op(OP_POP, 8'h00, 3'd0, 2'd0, 7'd0, 8'd0);
        send_op(OP_MODE, 8'h00, 3'd6, 2'd0, 7'd0, 8'd0);
        scan_key(8'd20);
        scan_key(8'd14);
        scan_key(8'd14);
        scan_key(8'd16);
        scan_key(8'd42);
        scan_key(EXT_PREFIX);
        scan_key(EXT_PREFIX);
        scan_key(8'd73 | 8'h80);
        scan_key(EXT_PREFIX);
        scan_key(8'd81 | 8'h80);
        scan_key(8'd42 | 8'h80);
        send_op(OP_MODE, 8'h00, 3'd5, 2'd0, 7'd0, 8'd0);
        scan_key(8'hFF);
        send_op(OP_POP, 8'h00, 3'd0, 2'd0, 7'd0, 8'd0);
        send_op(OP_MODE, 8'h00, 3'd0, 2'd0, 7'd0, 8'd0);
        scan_key(8'd0);
    endtask

    // Shift sequences, extended pairs, typing and pops in every mode
    task automatic test_random_traffic(input int count);
        int r;
        logic [7:0] sb;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send_op(OP_MODE, 8'($urandom), 3'($urandom), 2'($urandom), 7'($urandom),
                        8'($urandom));
            else if (r < 25)
                send_op(OP_POP, 8'($urandom), 3'($urandom), 2'($urandom), 7'($urandom),
                        8'($urandom));
            else if (r < 28)
                send_op(OP_LOAD, 8'($urandom), 3'($urandom), 2'($urandom), 7'($urandom),
                        8'($urandom_range(0, 255)));
            else if (r < 38)
            begin
                scan_key(EXT_PREFIX);
                sb = ($urandom_range(0, 1)) ? {1'b1, key_regs[REG_PGUP + $urandom_range(0, 1)]}
                     : 8'($urandom);
                scan_key(sb);
                i++;
            end
            else if (r < 50)
            begin
                sb = {$urandom_range(0, 1) == 1, key_regs[$urandom_range(0, 3)]};
                scan_key(sb);
            end
            else if (r < 55)
                scan_key(8'd16);
            else
                scan_key({1'($urandom_range(0, 1)), pick_code()});
            if (($urandom_range(0, 199)) == 0)
                wait_drained();
        end
    endtask

    // Register changes, including collisions and extremes
    task automatic test_register_sweep();
        wait_drained();
        write_reg(REG_LSHIFT, 7'd0);
        write_reg(REG_RSHIFT, 7'd127);
        write_reg(REG_CAPS, 7'd127);
        write_reg(REG_BKSP, 7'd0);
        write_reg(REG_PGUP, 7'd127);
        write_reg(REG_PGDN, 7'd0);
        test_random_traffic(60);
        wait_drained();
        for (int i = 0; i < 6; i++)
            write_reg(3'(i), pick_code());
        test_random_traffic(60);
        wait_drained();
        write_reg(REG_LSHIFT, 7'd42);
        write_reg(REG_RSHIFT, 7'd54);
        write_reg(REG_CAPS, 7'd58);
        write_reg(REG_BKSP, 7'd14);
        write_reg(REG_PGUP, 7'd73);
        write_reg(REG_PGDN, 7'd81);
    endtask

    // Overfill line store then queue
    task automatic test_overflow();
        send_op(OP_MODE, 8'h00, 3'd2, 2'd0, 7'd0, 8'd0);
        for (int s = 0; s < 4; s++)
        begin
            send_op(OP_LOAD, 8'h00, 3'd0, 2'(s), 7'd20, 8'h41);
            send_op(OP_LOAD, 8'h00, 3'd0, 2'(s), 7'd16, 8'h0A);
        end
        for (int i = 0; i < 66; i++)
            scan_key(8'd20);
        scan_key(8'd16);
        for (int i = 0; i < 66; i++)
            scan_key(8'd20);
        send_op(OP_MODE, 8'h00, 3'd0, 2'd0, 7'd0, 8'd0);
        for (int i = 0; i < 70; i++)
            send_op(OP_POP, 8'h00, 3'd0, 2'd0, 7'd0, 8'd0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycle_count = 0;
        err_count = 0;
        beat_count = 0;
        sink_wait = 0;
        sink_stall_on = 1'b1;
        shift_held = 2'b00;
        caps_on = 1'b0;
        ext_wait = 1'b0;
        mode_bits = 3'd0;
        keyq_head = 0;
        keyq_fill = 0;
        line_fill = 0;
        key_regs = '{7'd42, 7'd54, 7'd58, 7'd14, 7'd73, 7'd81};
        for (int i = 0; i < 512; i++)
        begin
            xlat[i] = 8'h00;
            xlat_known[i] = 1'b0;
        end
        for (int i = 0; i < 8; i++)
            kind_seen[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_load();
        test_directed();
        wait_drained();
        test_overflow();
        test_random_traffic(120);
        sink_stall_on = 1'b0;
        test_register_sweep();
        sink_stall_on = 1'b1;
        test_random_traffic(100);
        wait_drained();
        $display("covered %0d result beats: echo %0d pop %0d bksp %0d scroll %0d/%0d led %0d",
                 beat_count, kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
                 kind_seen[5], kind_seen[6]);
        $display("table loads, mode changes, register sweeps and queue overflow exercised");
        if (err_count == 0 && pending_events.size() == 0)
            $display("scancode_keyboard_line_discipline_core test passed");
        else
            $display("scancode_keyboard_line_discipline_core test failed");
        $finish;
    end

endmodule
